/* hdl/radar_sweep_gap_filler_core_macros.svh */
// Assertion macros shared by the checker files.
`ifndef RADAR_SWEEP_GAP_FILLER_CORE_MACROS_SVH
`define RADAR_SWEEP_GAP_FILLER_CORE_MACROS_SVH
// Implication checked every clock edge outside reset.
`define RSGF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RSGF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/rsgf_pkg.sv */
//------------------------------------------------------------------------------
// rsgf_pkg
// Shared constants for the radar sweep gap filler.
//------------------------------------------------------------------------------
package rsgf_pkg;
  localparam int ANGLE_COUNT_DEF = 4096;
  localparam int MAX_BINS_DEF    = 1024;
  localparam int MAX_GAP_DEF     = 64;
  localparam int ANGLE_W = 12;
  localparam int BIN_W   = 10;
  localparam int SAMP_W  = 16;
  localparam int CFG_W   = 11;
  localparam logic [1:0] ACT_FIRST = 2'd0;
  localparam logic [1:0] ACT_MEAN  = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;
  localparam logic [1:0] ACT_OVER  = 2'd3;
endpackage

/* hdl/radar_sweep_gap_filler_core.sv */
// Flow: an accepted sample passes S_RD and S_EXEC before its result is valid;
//   a fill row adds the multiply state S_MUL and the 25-step restoring divider.
// A new sample is taken only in S_IDLE, after the last write of the previous
//   one (every row of a fill) is accepted; out_ready low holds a result back.
// Reset: synchronous active-low rst_n clears control state; the line store
//   is not cleared and needs no clearing pass.
//------------------------------------------------------------------------------
// radar_sweep_gap_filler_core
// Averages repeated lines, interpolates missing azimuth rows, passes others on.
//------------------------------------------------------------------------------
module radar_sweep_gap_filler_core
  import rsgf_pkg::*;
#(
  parameter int MAX_GAP     = MAX_GAP_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ANGLE_W-1:0]       in_angle,
  input  logic [BIN_W-1:0]         in_range_bin,
  input  logic signed [SAMP_W-1:0] in_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ANGLE_W-1:0]       out_row,
  output logic [BIN_W-1:0]         out_column,
  output logic signed [SAMP_W-1:0] out_value,
  output logic                     out_last_of_run,
  output logic                     out_sweep_done,
  output logic                     out_gap_overflow
);
  localparam int AW   = ANGLE_W;
  localparam int RW   = $clog2(ANGLE_COUNT_DEF + 1);
  localparam int GW   = $clog2(MAX_GAP + 1);
  localparam int NW   = SAMP_W + 2 + GW;   // |diff*j| magnitude width
  localparam int DSTP = NW;                // divider steps
  localparam int SCW  = $clog2(DSTP + 1);
  localparam int AMW  = $clog2(MAX_BINS_DEF);

  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_EXEC = 3'd2,
                         S_MUL = 3'd3, S_DIV = 3'd4, S_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [CFG_W-1:0] bins_r;
  logic [AW-1:0] prev_r;
  logic [RW-1:0] rows_r;
  logic [1:0] act_r;
  logic [GW-1:0] gap_r;
  logic first_r;

  logic [BIN_W-1:0] bin_r;
  logic signed [SAMP_W-1:0] b_r, a_r;
  logic [GW-1:0] j_r, cnt_r;
  logic lastbin_r;
  logic signed [SAMP_W:0] diff_r;
  logic [NW-1:0] rem_r, quo_r;
  logic neg_r;
  logic [SCW-1:0] step_r;
  logic ram_we;
  logic [SAMP_W-1:0] ram_rd;

  // effective line length: 0 acts as 1, clipped to MAX_BINS
  logic [CFG_W-1:0] bins_eff;
  always_comb begin
    bins_eff = bins_r;
    if (bins_r == '0) bins_eff = CFG_W'(1);
    if (32'(bins_r) > MAX_BINS_DEF) bins_eff = CFG_W'(MAX_BINS_DEF);
  end

  logic bin_ok;
  assign bin_ok = (CFG_W'(in_range_bin) < bins_eff);

  logic [AW-1:0] ang_in;
  assign ang_in = AW'(32'(in_angle) % ANGLE_COUNT_DEF);
  logic [AW-1:0] dstep;
  assign dstep = ang_in - prev_r;

  assign in_ready = (state_r == S_IDLE);

  rsgf_ram #(.WIDTH(SAMP_W), .DEPTH(MAX_BINS_DEF)) u_store (
    .clk(clk), .we(ram_we), .addr(bin_r[AMW-1:0]),
    .wdata(act_r == ACT_MEAN ? out_value : b_r), .rdata(ram_rd));

  logic [GW-1:0] d_eff;
  assign d_eff = (gap_r == '0) ? GW'(1) : gap_r;

  // divider trial subtract
  logic [NW-1:0] rem_sh;
  logic [NW:0] trial;
  assign rem_sh = {rem_r[NW-2:0], quo_r[NW-1]};
  assign trial = {1'b0, rem_sh} - (NW+1)'(d_eff);

  // quotient after the last step, sign restored
  logic [NW-1:0] quo_fin;
  assign quo_fin = {quo_r[NW-2:0], ~trial[NW]};
  logic signed [NW:0] q_s;
  assign q_s = neg_r ? -$signed({1'b0, quo_fin}) : $signed({1'b0, quo_fin});

  logic out_fire;
  assign out_fire = out_valid && out_ready;
  logic [RW-1:0] room;
  assign room = RW'(ANGLE_COUNT_DEF) - rows_r;

  assign ram_we = out_fire && out_last_of_run;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && bin_ok) state_nxt = S_RD;
      S_RD:   state_nxt = S_EXEC;
      S_EXEC: state_nxt = (act_r == ACT_FILL) ? S_MUL : S_OUT;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (step_r == SCW'(DSTP - 1)) state_nxt = S_OUT;
      S_OUT:  if (out_ready) begin
                if (out_last_of_run) state_nxt = S_IDLE;
                else state_nxt = S_MUL;
              end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bins_r  <= CFG_W'(MAX_BINS_DEF);
      prev_r  <= '0;
      rows_r  <= '0;
      act_r   <= ACT_FIRST;
      gap_r   <= '0;
      first_r <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) bins_r <= cfg_wdata;
      // line classification on transfer of bin 0
      if (state_r == S_IDLE && in_valid && bin_ok && in_range_bin == '0) begin
        prev_r <= ang_in;
        if (first_r) begin
          act_r <= ACT_FIRST;
          gap_r <= '0;
          first_r <= 1'b0;
        end else begin
          gap_r <= (32'(dstep) <= MAX_GAP) ? GW'(dstep) : '0;
          if (dstep == '0) act_r <= ACT_MEAN;
          else if (32'(dstep) <= MAX_GAP) act_r <= ACT_FILL;
          else act_r <= ACT_OVER;
        end
      end
      if ((state_r == S_EXEC && act_r != ACT_FILL) ||
          (state_r == S_DIV && step_r == SCW'(DSTP - 1))) out_valid <= 1'b1;
      else if (out_fire) out_valid <= 1'b0;
      // row count advances at the line end
      if (out_fire && out_last_of_run && lastbin_r) begin
        if (out_sweep_done) rows_r <= '0;
        else if (act_r == ACT_FILL) rows_r <= rows_r + RW'(cnt_r);
        else if (act_r != ACT_MEAN) rows_r <= rows_r + RW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        bin_r <= in_range_bin;
        b_r   <= in_sample;
        lastbin_r <= (CFG_W'(in_range_bin) == bins_eff - CFG_W'(1));
      end
      S_RD: ;
      S_EXEC: begin
        a_r <= $signed(ram_rd);
        diff_r <= (SAMP_W+1)'(b_r) - (SAMP_W+1)'($signed(ram_rd));
        j_r <= GW'(1);
        cnt_r <= (RW'(d_eff) < room) ? d_eff : GW'(room);
        out_column <= bin_r;
        out_row <= prev_r;
        out_gap_overflow <= (act_r == ACT_OVER);
        out_last_of_run <= 1'b1;
        out_value <= (act_r == ACT_MEAN) ?
          SAMP_W'(((SAMP_W+1)'(b_r) + (SAMP_W+1)'($signed(ram_rd))) / 2) : b_r;
        out_sweep_done <= lastbin_r && (act_r != ACT_MEAN) &&
                          (rows_r + RW'(1) >= RW'(ANGLE_COUNT_DEF));
      end
      S_MUL: begin
        // one multiply per row, magnitude taken for the divider
        neg_r <= diff_r[SAMP_W];
        quo_r <= diff_r[SAMP_W] ? NW'(-(diff_r * $signed({1'b0, j_r})))
                                : NW'(diff_r * $signed({1'b0, j_r}));
        rem_r <= '0;
        step_r <= '0;
      end
      S_DIV: begin
        step_r <= step_r + SCW'(1);
        if (!trial[NW]) begin
          rem_r <= trial[NW-1:0];
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
        if (step_r == SCW'(DSTP - 1)) begin
          out_column <= bin_r;
          out_gap_overflow <= 1'b0;
          out_row <= prev_r - AW'(d_eff) + AW'(j_r);
          out_last_of_run <= (j_r == cnt_r);
          out_value <= SAMP_W'((NW+1)'(a_r) + q_s);
          out_sweep_done <= (j_r == cnt_r) && lastbin_r &&
                            (rows_r + RW'(cnt_r) >= RW'(ANGLE_COUNT_DEF));
        end
      end
      S_OUT: if (out_ready) j_r <= j_r + GW'(1);
      default: ;
    endcase
  end
endmodule

/* hdl/rsgf_ram.sv */
//------------------------------------------------------------------------------
// rsgf_ram
// Generic single-port RAM with registered read.
//------------------------------------------------------------------------------
module rsgf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hdl/rsgf_checker.sv */
//------------------------------------------------------------------------------
// rsgf_checker
// Port-level checks for the gap filler core.
//------------------------------------------------------------------------------
`include "radar_sweep_gap_filler_core_macros.svh"
module rsgf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last_of_run,
  input logic out_sweep_done,
  input logic out_gap_overflow
);
  // no new transfer while a result is pending
  `RSGF_ASSERT_IMP(a_busy, clk, rst_n, out_valid, !in_ready)
  // sweep end only on the final write of a sample
  `RSGF_ASSERT_IMP(a_sweep, clk, rst_n, out_valid && out_sweep_done, out_last_of_run)
  // overflow writes are single
  `RSGF_ASSERT_IMP(a_over, clk, rst_n, out_valid && out_gap_overflow, out_last_of_run)
  // stalled result holds
  `RSGF_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind radar_sweep_gap_filler_core rsgf_checker u_rsgf_checker (.*);

/* tb/sv/testbench.sv */
//------------------------------------------------------------------------------
// Radar sweep gap filler testbench
// Drives echo samples through the core and checks every image write against
// a cycle-free prediction of the row, column, value and flags. Each test task
// covers one behavior: first lines, repeated angles, fills, gap overflow, odd
// line lengths, sweep wrap and random lines. Both sides stall at random.
//------------------------------------------------------------------------------
module testbench
  import rsgf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [ANGLE_W-1:0]       row;
    logic [BIN_W-1:0]         column;
    logic signed [SAMP_W-1:0] value;
    logic                     last_of_run;
    logic                     sweep_done;
    logic                     gap_overflow;
  } image_write_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [ANGLE_W-1:0]       in_angle;
  logic [BIN_W-1:0]         in_range_bin;
  logic signed [SAMP_W-1:0] in_sample;
  logic                     out_valid;
  logic                     out_ready;
  logic [ANGLE_W-1:0]       out_row;
  logic [BIN_W-1:0]         out_column;
  logic signed [SAMP_W-1:0] out_value;
  logic                     out_last_of_run;
  logic                     out_sweep_done;
  logic                     out_gap_overflow;

  // Shadow of the core state
  logic signed [SAMP_W-1:0] prev_line [MAX_BINS_DEF];
  bit                       bin_written [MAX_BINS_DEF];
  int                       prev_angle;
  int                       rows_in_sweep;
  logic [1:0]               cur_action;
  int                       cur_gap;
  bit                       first_pending;
  int                       line_len_reg;

  image_write_t expected_writes[$];
  int           errors;
  int           cycles = 0;
  bit           no_stall;

  radar_sweep_gap_filler_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_angle         (in_angle),
    .in_range_bin     (in_range_bin),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row          (out_row),
    .out_column       (out_column),
    .out_value        (out_value),
    .out_last_of_run  (out_last_of_run),
    .out_sweep_done   (out_sweep_done),
    .out_gap_overflow (out_gap_overflow)
  );

  // Clock, 12 ns period
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int line_len();
    if (line_len_reg == 0) return 1;
    if (line_len_reg > MAX_BINS_DEF) return MAX_BINS_DEF;
    return line_len_reg;
  endfunction

  function automatic bit line_complete();
    for (int i = 0; i < line_len(); i++) begin
      if (!bin_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Work out the image writes one accepted sample causes
  task automatic predict_writes(input int ang, input int bin, input int smp);
    image_write_t burst[$];
    image_write_t w;
    int a, b, room, span, cnt, inc, d;
    a = 0;
    b = smp;
    inc = 0;
    if (bin >= line_len()) return;
    if (bin == 0) begin
      if (first_pending) begin
        cur_action = ACT_FIRST;
        cur_gap = 0;
        first_pending = 1'b0;
      end else begin
        d = (ang + ANGLE_COUNT_DEF - prev_angle) % ANGLE_COUNT_DEF;
        cur_gap = d;
        if (d == 0) cur_action = ACT_MEAN;
        else if (d <= MAX_GAP_DEF) cur_action = ACT_FILL;
        else cur_action = ACT_OVER;
      end
      prev_angle = ang;
    end
    a = prev_line[bin];
    room = ANGLE_COUNT_DEF - rows_in_sweep;
    w.column = BIN_W'(bin);
    w.last_of_run = 1'b0;
    w.sweep_done = 1'b0;
    w.gap_overflow = 1'b0;
    case (cur_action)
      ACT_MEAN: begin
        w.row = ANGLE_W'(prev_angle);
        w.value = SAMP_W'((a + b) / 2);
        burst = {burst, w};
        prev_line[bin] = w.value;
      end
      ACT_FILL: begin
        span = (cur_gap == 0) ? 1 : cur_gap;
        cnt = (span < room) ? span : room;
        for (int j = 1; j <= cnt; j++) begin
          w.row = ANGLE_W'((prev_angle + ANGLE_COUNT_DEF - span + j) % ANGLE_COUNT_DEF);
          w.value = SAMP_W'(a + ((b - a) * j) / span);
          burst = {burst, w};
        end
        prev_line[bin] = SAMP_W'(b);
        inc = cnt;
      end
      default: begin
        w.row = ANGLE_W'(prev_angle);
        w.value = SAMP_W'(b);
        w.gap_overflow = (cur_action == ACT_OVER);
        burst = {burst, w};
        prev_line[bin] = SAMP_W'(b);
        inc = 1;
      end
    endcase
    bin_written[bin] = 1'b1;
    burst[burst.size()-1].last_of_run = 1'b1;
    if (bin == line_len() - 1) begin
      rows_in_sweep += inc;
      if (rows_in_sweep >= ANGLE_COUNT_DEF) begin
        burst[burst.size()-1].sweep_done = 1'b1;
        rows_in_sweep = 0;
      end
    end
    foreach (burst[i]) expected_writes = {expected_writes, burst[i]};
  endtask

  // Result side: random stall before each transfer, then compare
  initial begin
    int k;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      k = no_stall ? 0 : $urandom_range(0, 8);
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    image_write_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write row %0d col %0d", out_row, out_column));
      end else begin
        e = expected_writes.pop_front();
        if (out_row !== e.row)
          report_mismatch($sformatf("row %0d, want %0d", out_row, e.row));
        if (out_column !== e.column)
          report_mismatch($sformatf("column %0d, want %0d", out_column, e.column));
        if (out_value !== e.value)
          report_mismatch($sformatf("value %0d, want %0d (row %0d)", out_value, e.value, e.row));
        if (out_last_of_run !== e.last_of_run)
          report_mismatch($sformatf("last_of_run %b, want %b", out_last_of_run, e.last_of_run));
        if (out_sweep_done !== e.sweep_done)
          report_mismatch($sformatf("sweep_done %b, want %b", out_sweep_done, e.sweep_done));
        if (out_gap_overflow !== e.gap_overflow)
          report_mismatch($sformatf("gap_overflow %b, want %b", out_gap_overflow,
                                    e.gap_overflow));
      end
    end
  end

  // One sample transfer; called and returns at a falling edge
  task automatic send_sample(input int ang, input int bin, input int smp);
    int k;
    k = no_stall ? 0 : $urandom_range(0, 8);
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(negedge clk);
    end
    in_angle     <= ANGLE_W'(ang);
    in_range_bin <= BIN_W'(bin);
    in_sample    <= SAMP_W'(smp);
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_writes(ang % ANGLE_COUNT_DEF, bin, smp);
    @(negedge clk);
  endtask

  // Wait until every expected write has arrived, plus the core's latency
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_line_len(input int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    line_len_reg = v;
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  // Whole lines with random content plus some noise
  task automatic random_lines(input int n_items);
    int sent, d, ang, bin, len;
    sent = 0;
    while (sent < n_items) begin
      len = line_len();
      // repeated or filled lines only once the stored line is complete
      if (!first_pending && line_complete()) begin
        case ($urandom_range(0, 9))
          0, 1:    d = 0;
          2, 3, 4,
          5, 6:    d = $urandom_range(1, MAX_GAP_DEF);
          7, 8:    d = $urandom_range(MAX_GAP_DEF + 1, ANGLE_COUNT_DEF - 1);
          default: d = $urandom_range(0, ANGLE_COUNT_DEF - 1);
        endcase
      end else begin
        d = $urandom_range(MAX_GAP_DEF + 1, ANGLE_COUNT_DEF - 1);
      end
      ang = (prev_angle + d) % ANGLE_COUNT_DEF;
      send_sample(ang, 0, rand_sample());
      sent++;
      for (int i = 1; i < len && sent < n_items; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: out-of-range bin or a repeated bin of this line
          if (len < MAX_BINS_DEF) bin = $urandom_range(len, MAX_BINS_DEF - 1);
          else bin = $urandom_range(1, i);
          if (bin < len && !bin_written[bin]) bin = i;
          send_sample($urandom_range(0, ANGLE_COUNT_DEF - 1), bin, rand_sample());
          if (bin < len) sent++;
        end
        // angle field is ignored after the line start
        send_sample($urandom_range(0, ANGLE_COUNT_DEF - 1), i, rand_sample());
        sent++;
      end
    end
  endtask

  task automatic send_line(input int ang, input int s0, input int s1, input int s2,
                           input int s3);
    send_sample(ang, 0, s0);
    send_sample(ang, 1, s1);
    send_sample(ang, 2, s2);
    send_sample(ang, 3, s3);
  endtask

  // First line, including a sample before any line start and an ignored bin
  task automatic test_first_line();
    write_line_len(4);
    send_sample(17, 2, 100);
    send_line(4095, -32768, 32767, -1, 0);
    send_sample(0, 1023, 55);
  endtask

  // Same angle: averaged, truncating toward zero
  task automatic test_mean();
    send_line(4095, 32767, -32768, 0, -2);
  endtask

  // Gap of one across the wrap, then the widest fill
  task automatic test_fill();
    send_line(0, -32768, 32767, 7, -7);
    send_line(MAX_GAP_DEF, 32767, -32768, -5, 3);
  endtask

  // Gap just past the limit
  task automatic test_overflow();
    send_line(MAX_GAP_DEF + MAX_GAP_DEF + 1, 1234, -4321, 32767, -32768);
  endtask

  // Register at zero acts as one; above the maximum acts as the maximum
  task automatic test_odd_length();
    write_line_len(0);
    send_sample(130, 0, -9);
    send_sample(130, 1, 9);
    write_line_len(2047);
    send_sample(2000, 0, 321);
    send_sample(2000, 1023, -321);
    write_line_len(1024);
    send_sample(3000, 0, 11);
  endtask

  // Widest fills until the sweep ends, with a partial fill at the end
  task automatic test_sweep_wrap();
    write_line_len(1);
    no_stall = 1'b1;
    send_sample((prev_angle + 2000) % ANGLE_COUNT_DEF, 0, 77);
    for (int i = 0; i < 68; i++)
      send_sample((prev_angle + MAX_GAP_DEF) % ANGLE_COUNT_DEF, 0, rand_sample());
    no_stall = 1'b0;
    drain();
  endtask

  task automatic test_random();
    int lens[6] = '{3, 1, 8, 2, 16, 5};
    foreach (lens[i]) begin
      write_line_len(lens[i]);
      random_lines(30);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_angle = '0;
    in_range_bin = '0;
    in_sample = '0;
    errors = 0;
    no_stall = 1'b0;
    prev_angle = 0;
    rows_in_sweep = 0;
    cur_action = ACT_FIRST;
    cur_gap = 0;
    first_pending = 1'b1;
    line_len_reg = MAX_BINS_DEF;
    foreach (prev_line[i]) begin
      prev_line[i] = '0;
      bin_written[i] = 1'b0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_first_line();
    test_mean();
    test_fill();
    test_overflow();
    test_odd_length();
    test_sweep_wrap();
    test_random();

    drain();
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* radar_sweep_gap_filler_core.f */
+incdir+hdl
hdl/rsgf_pkg.sv
hdl/rsgf_ram.sv
hdl/radar_sweep_gap_filler_core.sv
hdl/rsgf_checker.sv
tb/sv/testbench.sv
